>>> hdl/elq_pkg.sv
// Shared types and constants for the expiring line queue.
package elq_pkg;

  localparam int DEPTH   = 64;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int WORD_W  = 32;
  localparam int CAP_W   = 7;
  localparam int TOTAL_W = 7;
  localparam int IDX_W   = 6;
  localparam int STEP_W  = 31;
  localparam int OP_W    = 2;

  // Small queues between the stages
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = 1;
  localparam int QFILL_W = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

  typedef enum logic [OP_W-1:0] {
    OP_PUSH    = 2'd0,
    OP_ADVANCE = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_READ    = 2'd3
  } op_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] start_x;
    logic signed [WORD_W-1:0] start_y;
    logic signed [WORD_W-1:0] start_z;
    logic signed [WORD_W-1:0] end_x;
    logic signed [WORD_W-1:0] end_y;
    logic signed [WORD_W-1:0] end_z;
    logic        [WORD_W-1:0] colour;
    logic signed [WORD_W-1:0] remain;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    op_t               op;
    entry_t            entry;
    logic [STEP_W-1:0] step;
    logic [IDX_W-1:0]  idx;
  } cmd_t;

  typedef struct packed {
    logic               valid;
    entry_t             entry;
    logic [TOTAL_W-1:0] total;
    logic [WORD_W-1:0]  dropped;
  } res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ_WAIT,
    ST_SWEEP
  } eng_state_t;

endpackage

>>> hdl/expiring_line_queue.sv
// Top level of the expiring line queue: front end, engine and result queue.
//
// - Input side is a queue: drive the op and its fields, raise push; the op is
//   taken at an edge where push is high and full is low. Ops: push entry,
//   advance time, clear, read entry.
// - Result side is a queue: while empty is low the oldest result is on the
//   out_ ports; pop at an edge with empty low completes the transfer.
//   Every op gives exactly one result, in order.
// - cfg_we/cfg_wdata write the capacity limit; write it only while idle.
// - Push, clear, a miss read and an advance of an empty store reach the result
//   queue in the cycle the engine takes them; a hit read first waits for the
//   registered store read, and an advance sweeps the held entries one by one.
// - Throughput: one push, clear or missed read per cycle while ops wait and
//   the result queue has room; a hit read or an advance holds the engine until
//   done, set by the single read port of the line store (one entry per cycle).
// - Two-deep queues sit before and after the engine. When the receiver stalls
//   the result queue fills, the engine waits and full rises once the command
//   queue is full; nothing is lost.
// - Reset (synchronous, rst_n low) empties both queues, zeroes the entry and
//   drop counts and sets the capacity to 64. Store contents are left.
module expiring_line_queue (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  output logic                       full,
  input  logic [elq_pkg::OP_W-1:0]   in_op,
  input  logic signed [31:0]         in_start_x,
  input  logic signed [31:0]         in_start_y,
  input  logic signed [31:0]         in_start_z,
  input  logic signed [31:0]         in_end_x,
  input  logic signed [31:0]         in_end_y,
  input  logic signed [31:0]         in_end_z,
  input  logic [31:0]                in_colour,
  input  logic signed [31:0]         in_lifetime,
  input  logic [elq_pkg::STEP_W-1:0] in_time_step,
  input  logic [elq_pkg::IDX_W-1:0]  in_read_index,
  output logic                       empty,
  input  logic                       pop,
  output logic                       out_valid_res,
  output logic signed [31:0]         out_start_x,
  output logic signed [31:0]         out_start_y,
  output logic signed [31:0]         out_start_z,
  output logic signed [31:0]         out_end_x,
  output logic signed [31:0]         out_end_y,
  output logic signed [31:0]         out_end_z,
  output logic [31:0]                out_colour,
  output logic signed [31:0]         out_remaining_time,
  output logic [elq_pkg::TOTAL_W-1:0] out_entry_total,
  output logic [31:0]                out_dropped_total,
  input  logic                       cfg_we,
  input  logic [elq_pkg::CAP_W-1:0]  cfg_wdata
);
  import elq_pkg::*;

  cmd_t cmd;
  logic cmd_avail;
  logic cmd_take;
  logic res_push;
  logic res_full;
  res_t res;
  res_t res_head;

  // Decoded ops wait here until the engine is free
  elq_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_op         (in_op),
    .in_start_x    (in_start_x),
    .in_start_y    (in_start_y),
    .in_start_z    (in_start_z),
    .in_end_x      (in_end_x),
    .in_end_y      (in_end_y),
    .in_end_z      (in_end_z),
    .in_colour     (in_colour),
    .in_lifetime   (in_lifetime),
    .in_time_step  (in_time_step),
    .in_read_index (in_read_index),
    .cmd           (cmd),
    .cmd_avail     (cmd_avail),
    .cmd_take      (cmd_take)
  );

  // Engine owns the line store, the counters and the capacity register
  elq_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .cmd_avail (cmd_avail),
    .cmd_take  (cmd_take),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  // Finished results, oldest first
  elq_resq u_resq (
    .clk      (clk),
    .rst_n    (rst_n),
    .res_push (res_push),
    .res_in   (res),
    .res_full (res_full),
    .pop      (pop),
    .empty    (empty),
    .res_out  (res_head)
  );

  assign out_valid_res      = res_head.valid;
  assign out_start_x        = res_head.entry.start_x;
  assign out_start_y        = res_head.entry.start_y;
  assign out_start_z        = res_head.entry.start_z;
  assign out_end_x          = res_head.entry.end_x;
  assign out_end_y          = res_head.entry.end_y;
  assign out_end_z          = res_head.entry.end_z;
  assign out_colour         = res_head.entry.colour;
  assign out_remaining_time = res_head.entry.remain;
  assign out_entry_total    = res_head.total;
  assign out_dropped_total  = res_head.dropped;

endmodule

>>> hdl/elq_ram.sv
// Simple dual-port RAM, one write and one registered read port.
module elq_ram #(
  parameter int DATA_W = 256,
  parameter int ADDR_W = 6,
  parameter int WORDS  = 64
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/elq_front.sv
// Front end: accepts ops, decodes them and holds them in a short command queue.
module elq_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic [elq_pkg::OP_W-1:0]      in_op,
  input  logic signed [31:0]            in_start_x,
  input  logic signed [31:0]            in_start_y,
  input  logic signed [31:0]            in_start_z,
  input  logic signed [31:0]            in_end_x,
  input  logic signed [31:0]            in_end_y,
  input  logic signed [31:0]            in_end_z,
  input  logic [31:0]                   in_colour,
  input  logic signed [31:0]            in_lifetime,
  input  logic [elq_pkg::STEP_W-1:0]    in_time_step,
  input  logic [elq_pkg::IDX_W-1:0]     in_read_index,
  output elq_pkg::cmd_t                 cmd,
  output logic                          cmd_avail,
  input  logic                          cmd_take
);
  import elq_pkg::*;

  cmd_t               slots_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QFILL_W-1:0] fill_r, fill_nxt;
  logic               accept;
  logic               take;
  cmd_t               dec;

  assign full      = (fill_r == QFILL_W'(QDEPTH));
  assign accept    = push && !full;
  assign cmd_avail = (fill_r != '0);
  assign take      = cmd_take && cmd_avail;
  assign cmd       = slots_r[rd_ptr_r];

  // Decode into a command word
  always_comb begin
    dec.op           = op_t'(in_op);
    dec.entry.start_x = in_start_x;
    dec.entry.start_y = in_start_y;
    dec.entry.start_z = in_start_z;
    dec.entry.end_x   = in_end_x;
    dec.entry.end_y   = in_end_y;
    dec.entry.end_z   = in_end_z;
    dec.entry.colour  = in_colour;
    dec.entry.remain  = in_lifetime;
    dec.step         = in_time_step;
    dec.idx          = in_read_index;
  end

  always_comb begin
    wr_ptr_nxt = accept ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = take ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    fill_nxt   = fill_r + QFILL_W'(accept) - QFILL_W'(take);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      slots_r[wr_ptr_r] <= dec;
    end
  end

endmodule

>>> hdl/elq_resq.sv
// Result queue: holds finished results until the receiver pops them.
module elq_resq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          res_push,
  input  elq_pkg::res_t res_in,
  output logic          res_full,
  input  logic          pop,
  output logic          empty,
  output elq_pkg::res_t res_out
);
  import elq_pkg::*;

  res_t               slots_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QFILL_W-1:0] fill_r, fill_nxt;
  logic               wr;
  logic               rd;

  assign res_full = (fill_r == QFILL_W'(QDEPTH));
  assign empty    = (fill_r == '0);
  assign wr       = res_push && !res_full;
  assign rd       = pop && !empty;
  assign res_out  = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = rd ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    fill_nxt   = fill_r + QFILL_W'(wr) - QFILL_W'(rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      slots_r[wr_ptr_r] <= res_in;
    end
  end

endmodule

>>> hdl/elq_back.sv
// Back end: executes commands against the line store and builds results.
module elq_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [elq_pkg::CAP_W-1:0]  cfg_wdata,
  input  elq_pkg::cmd_t              cmd,
  input  logic                       cmd_avail,
  output logic                       cmd_take,
  input  logic                       res_full,
  output logic                       res_push,
  output elq_pkg::res_t              res
);
  import elq_pkg::*;

  eng_state_t         state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [WORD_W-1:0]  drop_r, drop_nxt;
  logic [CNT_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   kept_r, kept_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [CAP_W-1:0]   cap_r;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  entry_t             ram_wdata;
  logic               ram_re;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t             rd_entry;

  logic                     store_full;
  logic                     idx_hit;
  logic                     alive;
  logic signed [WORD_W:0]   diff;
  logic signed [WORD_W-1:0] new_remain;
  entry_t                   aged;

  elq_ram #(
    .DATA_W (ENTRY_W),
    .ADDR_W (ADDR_W),
    .WORDS  (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_entry = entry_t'(ram_rdata);

  // Effective capacity is min(capacity register, DEPTH)
  assign store_full = (TOTAL_W'(count_r) >= TOTAL_W'(cap_r)) || (count_r >= CNT_W'(DEPTH));
  assign idx_hit    = (TOTAL_W'(cmd.idx) < TOTAL_W'(count_r));

  // Ageing of the entry coming back from the store during a sweep
  assign alive = !rd_entry.remain[WORD_W-1] && (rd_entry.remain != '0);
  assign diff  = {rd_entry.remain[WORD_W-1], rd_entry.remain} - {2'b00, step_r};
  always_comb begin
    if (diff[WORD_W] && !diff[WORD_W-1]) begin
      new_remain = {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      new_remain = diff[WORD_W-1:0];
    end
    aged        = rd_entry;
    aged.remain = new_remain;
  end

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    drop_nxt   = drop_r;
    rd_ptr_nxt = rd_ptr_r;
    kept_nxt   = kept_r;
    step_nxt   = step_r;
    cmd_take   = 1'b0;
    res_push   = 1'b0;
    res        = '0;
    ram_we     = 1'b0;
    ram_waddr  = count_r[ADDR_W-1:0];
    ram_wdata  = cmd.entry;
    ram_re     = 1'b0;
    ram_raddr  = cmd.idx[ADDR_W-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (cmd_avail && !res_full) begin
          cmd_take = 1'b1;
          unique case (cmd.op)
            OP_PUSH: begin
              if (store_full) begin
                if (drop_r != '1) begin
                  drop_nxt = drop_r + WORD_W'(1);
                end
              end else begin
                ram_we    = 1'b1;
                count_nxt = count_r + CNT_W'(1);
              end
              res_push = 1'b1;
            end
            OP_CLEAR: begin
              count_nxt = '0;
              drop_nxt  = '0;
              res_push  = 1'b1;
            end
            OP_READ: begin
              if (idx_hit) begin
                ram_re    = 1'b1;
                state_nxt = ST_READ_WAIT;
              end else begin
                res_push = 1'b1;
              end
            end
            OP_ADVANCE: begin
              if (count_r == '0) begin
                res_push = 1'b1;
              end else begin
                ram_re     = 1'b1;
                ram_raddr  = '0;
                rd_ptr_nxt = CNT_W'(1);
                kept_nxt   = '0;
                step_nxt   = cmd.step;
                state_nxt  = ST_SWEEP;
              end
            end
            default: ;
          endcase
          res.total   = TOTAL_W'(count_nxt);
          res.dropped = drop_nxt;
        end
      end

      ST_READ_WAIT: begin
        res_push    = 1'b1;
        res.valid   = 1'b1;
        res.entry   = rd_entry;
        res.total   = TOTAL_W'(count_r);
        res.dropped = drop_r;
        state_nxt   = ST_IDLE;
      end

      ST_SWEEP: begin
        // Data of entry rd_ptr_r-1 is on the read port; keep and compact it if alive
        if (alive) begin
          ram_we    = 1'b1;
          ram_waddr = kept_r[ADDR_W-1:0];
          ram_wdata = aged;
          kept_nxt  = kept_r + CNT_W'(1);
        end
        if (rd_ptr_r < count_r) begin
          ram_re     = 1'b1;
          ram_raddr  = rd_ptr_r[ADDR_W-1:0];
          rd_ptr_nxt = rd_ptr_r + CNT_W'(1);
        end else begin
          count_nxt   = kept_nxt;
          res_push    = 1'b1;
          res.total   = TOTAL_W'(kept_nxt);
          res.dropped = drop_r;
          state_nxt   = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      drop_r  <= '0;
      cap_r   <= CAP_RESET;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      drop_r  <= drop_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_ptr_r <= rd_ptr_nxt;
    kept_r   <= kept_nxt;
    step_r   <= step_nxt;
  end

endmodule

>>> test/expiring_line_queue_test.sv
// Self-checking testbench for the expiring line queue: directed and random ops.
module expiring_line_queue_test;
  timeunit 1ns;
  timeprecision 1ps;

  import elq_pkg::*;

  // One step of the directed plan: either a capacity write or an op.
  // Where typed is set, the expected result is written in the row itself.
  typedef struct {
    bit                 is_cap;
    logic [CAP_W-1:0]   cap;
    cmd_t               cmd;
    bit                 typed;
    logic [TOTAL_W-1:0] total;
    logic [31:0]        dropped;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic cfg_we = 1'b0;
  logic [CAP_W-1:0] cfg_wdata = CAP_RESET;
  cmd_t drive_cmd = '0;

  logic full;
  logic empty;
  logic out_valid_res;
  logic signed [31:0] out_start_x;
  logic signed [31:0] out_start_y;
  logic signed [31:0] out_start_z;
  logic signed [31:0] out_end_x;
  logic signed [31:0] out_end_y;
  logic signed [31:0] out_end_z;
  logic [31:0] out_colour;
  logic signed [31:0] out_remaining_time;
  logic [TOTAL_W-1:0] out_entry_total;
  logic [31:0] out_dropped_total;

  // Shadow of the block: line store, counts and the capacity register.
  entry_t line_mem [DEPTH];
  int held_count = 0;
  logic [31:0] refused_count = '0;
  logic [CAP_W-1:0] cap_reg = CAP_RESET;

  res_t pending_results [$];   // results still owed by the block, oldest first
  plan_row_t directed_plan [$];
  int mismatches = 0;
  bit tx_calm = 1'b0;          // sender runs without gaps while set

  always #5 clk = ~clk;

  expiring_line_queue dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .push               (push),
    .full               (full),
    .in_op              (drive_cmd.op),
    .in_start_x         (drive_cmd.entry.start_x),
    .in_start_y         (drive_cmd.entry.start_y),
    .in_start_z         (drive_cmd.entry.start_z),
    .in_end_x           (drive_cmd.entry.end_x),
    .in_end_y           (drive_cmd.entry.end_y),
    .in_end_z           (drive_cmd.entry.end_z),
    .in_colour          (drive_cmd.entry.colour),
    .in_lifetime        (drive_cmd.entry.remain),
    .in_time_step       (drive_cmd.step),
    .in_read_index      (drive_cmd.idx),
    .empty              (empty),
    .pop                (pop),
    .out_valid_res      (out_valid_res),
    .out_start_x        (out_start_x),
    .out_start_y        (out_start_y),
    .out_start_z        (out_start_z),
    .out_end_x          (out_end_x),
    .out_end_y          (out_end_y),
    .out_end_z          (out_end_z),
    .out_colour         (out_colour),
    .out_remaining_time (out_remaining_time),
    .out_entry_total    (out_entry_total),
    .out_dropped_total  (out_dropped_total),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata)
  );

  // Applies one op to the shadow store and returns the result it owes.
  function automatic res_t line_queue_step(cmd_t c);
    res_t r;
    int eff_cap;
    int kept;
    longint rem;
    r = '0;
    // Capacity above the store depth behaves as the depth itself
    eff_cap = (int'(cap_reg) < DEPTH) ? int'(cap_reg) : DEPTH;
    case (c.op)
      OP_PUSH: begin
        if (held_count >= eff_cap) begin
          if (refused_count != 32'hFFFF_FFFF) refused_count++;
        end else begin
          line_mem[held_count] = c.entry;
          held_count++;
        end
      end
      OP_ADVANCE: begin
        // Expired entries (remaining <= 0) vanish before the step is taken;
        // survivors shift down in order and lose the step.
        kept = 0;
        for (int i = 0; i < held_count; i++) begin
          rem = longint'($signed(line_mem[i].remain));
          if (rem > 0) begin
            rem -= longint'(c.step);
            if (rem < -longint'(32'h8000_0000)) rem = -longint'(32'h8000_0000);
            line_mem[kept] = line_mem[i];
            line_mem[kept].remain = 32'(rem);
            kept++;
          end
        end
        held_count = kept;
      end
      OP_CLEAR: begin
        held_count = 0;
        refused_count = '0;
      end
      OP_READ: begin
        // Only positions below the count are ever returned
        if (int'(c.idx) < held_count) begin
          r.valid = 1'b1;
          r.entry = line_mem[c.idx];
        end
      end
    endcase
    r.total = TOTAL_W'(held_count);
    r.dropped = refused_count;
    return r;
  endfunction

  // Directed row; the six coordinates are spread from one base value so that
  // swapped or stuck coordinate lanes show up.
  function automatic void add_row(op_t op, logic [31:0] base, logic [31:0] colour,
                                  logic [31:0] life, logic [STEP_W-1:0] step,
                                  logic [IDX_W-1:0] idx, bit typed,
                                  logic [TOTAL_W-1:0] total, logic [31:0] dropped);
    plan_row_t row;
    row = '{default: '0};
    row.cmd.op = op;
    row.cmd.entry.start_x = base;
    row.cmd.entry.start_y = ~base;
    row.cmd.entry.start_z = base ^ 32'h0F0F_0F0F;
    row.cmd.entry.end_x = {base[15:0], base[31:16]};
    row.cmd.entry.end_y = 32'(0) - base;
    row.cmd.entry.end_z = ~(base ^ 32'h0F0F_0F0F);
    row.cmd.entry.colour = colour;
    row.cmd.entry.remain = life;
    row.cmd.step = step;
    row.cmd.idx = idx;
    row.typed = typed;
    row.total = total;
    row.dropped = dropped;
    directed_plan.insert(directed_plan.size(), row);
  endfunction

  function automatic void add_cap(logic [CAP_W-1:0] v);
    plan_row_t row;
    row = '{default: '0};
    row.is_cap = 1'b1;
    row.cap = v;
    directed_plan.insert(directed_plan.size(), row);
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endtask

  // Offers one op, waits for its transfer, records what it should return,
  // then idles for a random number of cycles.
  task automatic send_op(cmd_t c, bit typed, logic [TOTAL_W-1:0] total,
                         logic [31:0] dropped);
    res_t want;
    int gap;
    drive_cmd <= c;
    push <= 1'b1;
    do @(posedge clk); while (full);
    want = line_queue_step(c);
    if (typed) begin
      want = '0;
      want.total = total;
      want.dropped = dropped;
    end
    pending_results.insert(pending_results.size(), want);
    gap = tx_calm ? 0 : $urandom_range(7);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Capacity is only written once the block has drained every result.
  task automatic write_capacity(logic [CAP_W-1:0] v);
    push <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cap_reg = v;
    cfg_we <= 1'b0;
  endtask

  // Receiver: random pop gaps, calm stretches, and two long hold-offs so the
  // result and command queues fill and full is raised.
  initial begin : drain
    res_t want;
    res_t got;
    int gap;
    int taken;
    bit rx_calm;
    taken = 0;
    rx_calm = 1'b0;
    do @(posedge clk); while (!rst_n);
    pop <= 1'b1;
    forever begin
      @(posedge clk);
      if (pop && !empty) begin
        got.valid = out_valid_res;
        got.entry.start_x = out_start_x;
        got.entry.start_y = out_start_y;
        got.entry.start_z = out_start_z;
        got.entry.end_x = out_end_x;
        got.entry.end_y = out_end_y;
        got.entry.end_z = out_end_z;
        got.entry.colour = out_colour;
        got.entry.remain = out_remaining_time;
        got.total = out_entry_total;
        got.dropped = out_dropped_total;
        if (pending_results.size() == 0) begin
          $error("result transfer with nothing outstanding");
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_field("valid_res", want.valid, got.valid);
          check_field("start_x", want.entry.start_x, got.entry.start_x);
          check_field("start_y", want.entry.start_y, got.entry.start_y);
          check_field("start_z", want.entry.start_z, got.entry.start_z);
          check_field("end_x", want.entry.end_x, got.entry.end_x);
          check_field("end_y", want.entry.end_y, got.entry.end_y);
          check_field("end_z", want.entry.end_z, got.entry.end_z);
          check_field("colour", want.entry.colour, got.entry.colour);
          check_field("remaining_time", want.entry.remain, got.entry.remain);
          check_field("entry_total", want.total, got.total);
          check_field("dropped_total", want.dropped, got.dropped);
        end
        taken++;
        if (taken % 64 == 0) rx_calm = ($urandom_range(1) == 0);
        gap = rx_calm ? 0 : $urandom_range(7);
        if (taken == 300 || taken == 1000) gap = 400;
        if (gap > 0) begin
          pop <= 1'b0;
          repeat (gap) @(posedge clk);
          pop <= 1'b1;
        end
      end
    end
  end

  initial begin : stimulus
    cmd_t c;
    int pick;
    logic [CAP_W-1:0] phase_caps [8];

    // After reset: miss read and advance of an empty store
    add_row(OP_READ, 0, 0, 0, 0, 6'd0, 1, 0, 0);
    add_row(OP_ADVANCE, 0, 0, 0, 31'h7FFF_FFFF, 0, 1, 0, 0);
    // Capacity zero: every push is refused
    add_cap(7'd0);
    add_row(OP_PUSH, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0001_0000, 0, 0, 1, 0, 1);
    add_row(OP_PUSH, 32'h8000_0000, 0, 32'h7FFF_FFFF, 0, 0, 1, 0, 2);
    // Capacity above depth; pushes carrying extreme coordinates and lifetimes
    add_cap(7'h7F);
    add_row(OP_PUSH, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF,
            6'h3F, 1, 1, 2);
    add_row(OP_PUSH, 32'h7FFF_FFFF, 0, 0, 0, 0, 1, 2, 2);
    add_row(OP_PUSH, 32'h1234_5678, 32'h00FF_00FF, 32'h8000_0000, 0, 0, 1, 3, 2);
    add_row(OP_PUSH, 32'hDEAD_BEEF, 32'hA5A5_5A5A, 32'h0000_0001, 0, 0, 1, 4, 2);
    add_row(OP_PUSH, 32'h0001_0000, 32'h5A5A_A5A5, 32'h0001_0000, 0, 0, 1, 5, 2);
    add_row(OP_READ, 0, 0, 0, 0, 6'd0, 0, 0, 0);
    add_row(OP_READ, 0, 0, 0, 0, 6'd2, 0, 0, 0);
    add_row(OP_READ, 0, 0, 0, 0, 6'h3F, 1, 5, 2);
    // Zero step: entries with zero or negative lifetime expire
    add_row(OP_ADVANCE, 0, 0, 0, 0, 0, 1, 3, 2);
    add_row(OP_READ, 0, 0, 0, 0, 6'd1, 0, 0, 0);
    // Largest step drives the survivors to zero and below, none removed yet
    add_row(OP_ADVANCE, 0, 0, 0, 31'h7FFF_FFFF, 0, 1, 3, 2);
    add_row(OP_READ, 0, 0, 0, 0, 6'd0, 0, 0, 0);
    add_row(OP_READ, 0, 0, 0, 0, 6'd2, 0, 0, 0);
    add_row(OP_ADVANCE, 0, 0, 0, 31'd1, 0, 1, 0, 2);
    // Capacity lowered below the count: entries kept, pushes refused
    add_row(OP_PUSH, 32'h0BAD_F00D, 32'h1234_5678, 32'h0001_0000, 0, 0, 1, 1, 2);
    add_row(OP_PUSH, 32'hFFFF_FFFF, 0, 32'h7FFF_FFFF, 0, 0, 1, 2, 2);
    add_cap(7'd1);
    add_row(OP_PUSH, 0, 0, 32'h0001_0000, 0, 0, 1, 2, 3);
    add_row(OP_READ, 0, 0, 0, 0, 6'd1, 0, 0, 0);
    add_row(OP_CLEAR, 32'h5555_AAAA, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF,
            6'h3F, 1, 0, 0);

    phase_caps = '{7'd64, 7'h7F, 7'd0, 7'd1, 7'd65, 7'd13, 7'd64,
                   CAP_W'($urandom_range(127))};

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_plan[i]) begin
      if (directed_plan[i].is_cap) write_capacity(directed_plan[i].cap);
      else send_op(directed_plan[i].cmd, directed_plan[i].typed,
                   directed_plan[i].total, directed_plan[i].dropped);
    end

    // Random phases, one capacity each. Half the ops are pushes, mostly with live
    // lifetimes and short steps, so the store fills and sweeps have real work to do.
    for (int ph = 0; ph < 8; ph++) begin
      write_capacity(phase_caps[ph]);
      tx_calm = (ph % 3 == 1);
      repeat (175) begin
        c = '0;
        pick = $urandom_range(99);
        if (pick < 50) c.op = OP_PUSH;
        else if (pick < 65) c.op = OP_ADVANCE;
        else if (pick < 68) c.op = OP_CLEAR;
        else c.op = OP_READ;
        c.entry.start_x = $urandom;
        c.entry.start_y = $urandom;
        c.entry.start_z = $urandom;
        c.entry.end_x = $urandom;
        c.entry.end_y = $urandom;
        c.entry.end_z = $urandom;
        c.entry.colour = $urandom;
        pick = $urandom_range(9);
        if (pick < 8) c.entry.remain = $urandom_range(32'h0040_0000, 1);
        else if (pick == 8) c.entry.remain = $urandom;
        else c.entry.remain = 32'(0) - 32'($urandom_range(5));
        pick = $urandom_range(9);
        if (pick < 7) c.step = STEP_W'($urandom_range(32'h0002_0000));
        else if (pick < 9) c.step = '0;
        else c.step = STEP_W'($urandom);
        if (held_count > 0 && $urandom_range(4) != 0)
          c.idx = IDX_W'($urandom_range(held_count - 1));
        else
          c.idx = IDX_W'($urandom_range(63));
        send_op(c, 0, 0, 0);
      end
    end

    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // Room for a stray result from a full-depth sweep
    repeat (80) @(posedge clk);
    if (mismatches == 0) begin
      $display("expiring_line_queue_test passed");
    end else begin
      $display("expiring_line_queue_test failed");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("expiring_line_queue_test failed");
    $finish;
  end

endmodule

>>> sim.f
hdl/elq_pkg.sv
hdl/elq_ram.sv
hdl/elq_front.sv
hdl/elq_resq.sv
hdl/elq_back.sv
hdl/expiring_line_queue.sv
test/expiring_line_queue_test.sv
